// ===== rtl/simt_pkg.sv =====
// Shared constants, codes and types of the sorted interval merge table.
package simt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int POS_WIDTH_DEF   = 16;

    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_NEW     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MERGED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DONE    = 3'd4;

    // broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_MERGE_START,
        OP_MERGE_STEP
    } cell_op_t;

    // per-cell compare results, also read by the neighbor above
    typedef struct packed {
        logic r;      // valid and right >= a
        logic hit;    // overlaps [a, b]
        logic first;  // lowest overlapping cell
        logic ge;     // empty or left > b: at or above the insert slot
        logic ovl;    // marked cell overlaps its upper neighbor
        logic mark;   // holds the merged interval
    } cell_flags_t;

endpackage

// ===== rtl/simt_req_if.sv =====
// Request channel: command item with interval bounds and read index.
interface simt_req_if #(
    parameter int POS_WIDTH = simt_pkg::POS_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [simt_pkg::CMD_W-1:0]   command;
    logic [POS_WIDTH-1:0]         seg_left;
    logic [POS_WIDTH-1:0]         seg_right;
    logic [simt_pkg::INDEX_W-1:0] read_index;

    modport source (output valid, output command, output seg_left, output seg_right,
                    output read_index, input ready);
    modport sink   (input valid, input command, input seg_left, input seg_right,
                    input read_index, output ready);
endinterface

// ===== rtl/simt_rsp_if.sv =====
// Response channel: status, count and read-back entry.
interface simt_rsp_if #(
    parameter int POS_WIDTH = simt_pkg::POS_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [simt_pkg::STATUS_W-1:0] status;
    logic [simt_pkg::COUNT_W-1:0]  entry_count;
    logic [POS_WIDTH-1:0]          entry_left;
    logic [POS_WIDTH-1:0]          entry_right;
    logic                          entry_valid;

    modport source (output valid, output status, output entry_count, output entry_left,
                    output entry_right, output entry_valid, input ready);
    modport sink   (input valid, input status, input entry_count, input entry_left,
                    input entry_right, input entry_valid, output ready);
endinterface

// ===== rtl/sorted_interval_merge_table.sv =====
// Sorted interval merge table: a row of slot cells and its command sequencer.
// Insert without overlap, read, clear: the command passes S_EXEC, then S_OUT, which registers the result.
// Merge: S_EXEC, S_MERGE, S_OUT, with one compaction step in S_MERGE per extra stored interval absorbed
// (one compaction shift through the cell row per absorbed interval); S_OUT waits while the response stalls.
// Flow: one item in flight at a time; a new request is accepted only in S_IDLE.
// Reset: count and control cleared asynchronously; slot contents undefined until written.
module sorted_interval_merge_table #(
    parameter int TABLE_DEPTH = simt_pkg::TABLE_DEPTH_DEF,
    parameter int POS_WIDTH   = simt_pkg::POS_WIDTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    simt_req_if.sink   req,
    simt_rsp_if.source rsp
);
    import simt_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MERGE,
        S_OUT
    } state_t;

    state_t               state_reg,      state_next;
    logic [CMD_W-1:0]     cmd_reg,        cmd_next;
    logic [POS_WIDTH-1:0] a_reg,          a_next;
    logic [POS_WIDTH-1:0] b_reg,          b_next;
    logic [INDEX_W-1:0]   idx_reg,        idx_next;
    logic [CW-1:0]        count_reg,      count_next;
    logic [STATUS_W-1:0]  status_reg,     status_next;
    logic [POS_WIDTH-1:0] rd_left_reg,    rd_left_next;
    logic [POS_WIDTH-1:0] rd_right_reg,   rd_right_next;
    logic                 rd_valid_reg,   rd_valid_next;
    logic                 out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0]  out_status_reg, out_status_next;
    logic [COUNT_W-1:0]   out_count_reg,  out_count_next;
    logic [POS_WIDTH-1:0] out_left_reg,   out_left_next;
    logic [POS_WIDTH-1:0] out_right_reg,  out_right_next;
    logic                 out_ev_reg,     out_ev_next;

    cell_op_t             op;
    cell_flags_t          flags_w      [TABLE_DEPTH];
    cell_flags_t          prev_flags_w [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] cell_left    [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] cell_right   [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] prev_left_w  [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] prev_right_w [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] next_left_w  [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] next_right_w [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] sel_left_w   [TABLE_DEPTH];
    logic [POS_WIDTH-1:0] sel_right_w  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_vec;
    logic [TABLE_DEPTH-1:0] next_valid_vec;
    logic [TABLE_DEPTH-1:0] hit_vec;
    logic [TABLE_DEPTH-1:0] first_vec;
    logic [TABLE_DEPTH-1:0] ovl_vec;
    logic [TABLE_DEPTH-1:0] mark_vec;
    logic                 hit_any;
    logic                 any_ovl;
    logic                 in_range;
    logic [POS_WIDTH-1:0] rd_left_bus;
    logic [POS_WIDTH-1:0] rd_right_bus;
    logic [XW-1:0]        count_x;

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            localparam logic [CW-1:0] SLOT = CW'(g);
            localparam logic [IW-1:0] SLOT_I = IW'(g);

            assign valid_vec[g] = SLOT < count_reg;

            if (g == 0)
            begin : g_bottom
                assign prev_left_w[g]  = '0;
                assign prev_right_w[g] = '0;
                assign prev_flags_w[g] = '0;
            end
            else
            begin : g_mid
                assign prev_left_w[g]  = cell_left[g-1];
                assign prev_right_w[g] = cell_right[g-1];
                assign prev_flags_w[g] = flags_w[g-1];
            end

            if (g == TABLE_DEPTH - 1)
            begin : g_top
                assign next_left_w[g]    = '0;
                assign next_right_w[g]   = '0;
                assign next_valid_vec[g] = 1'b0;
            end
            else
            begin : g_low
                assign next_left_w[g]    = cell_left[g+1];
                assign next_right_w[g]   = cell_right[g+1];
                assign next_valid_vec[g] = valid_vec[g+1];
            end

            simt_cell #(
                .POS_WIDTH (POS_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (op),
                .a          (a_reg),
                .b          (b_reg),
                .valid      (valid_vec[g]),
                .next_valid (next_valid_vec[g]),
                .prev_left  (prev_left_w[g]),
                .prev_right (prev_right_w[g]),
                .next_left  (next_left_w[g]),
                .next_right (next_right_w[g]),
                .prev_flags (prev_flags_w[g]),
                .flags      (flags_w[g]),
                .left       (cell_left[g]),
                .right      (cell_right[g])
            );

            assign hit_vec[g]   = flags_w[g].hit;
            assign first_vec[g] = flags_w[g].first;
            assign ovl_vec[g]   = flags_w[g].ovl;
            assign mark_vec[g]  = flags_w[g].mark;

            // each cell drives the read bus only when addressed
            assign sel_left_w[g]  = (IW'(idx_reg) == SLOT_I) ? cell_left[g]  : '0;
            assign sel_right_w[g] = (IW'(idx_reg) == SLOT_I) ? cell_right[g] : '0;
        end
    endgenerate

    always_comb
    begin
        rd_left_bus  = '0;
        rd_right_bus = '0;
        for (int k = 0; k < TABLE_DEPTH; k++)
        begin
            rd_left_bus  = rd_left_bus  | sel_left_w[k];
            rd_right_bus = rd_right_bus | sel_right_w[k];
        end
    end

    assign hit_any  = |hit_vec;
    assign any_ovl  = |ovl_vec;
    assign in_range = (IW'(idx_reg) < IW'(count_reg)) && (IW'(idx_reg) < IW'(TABLE_DEPTH));
    assign count_x  = XW'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        rd_left_next    = rd_left_reg;
        rd_right_next   = rd_right_reg;
        rd_valid_next   = rd_valid_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_left_next   = out_left_reg;
        out_right_next  = out_right_reg;
        out_ev_next     = out_ev_reg;
        op              = OP_HOLD;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.command;
                    a_next     = req.seg_left;
                    b_next     = req.seg_right;
                    idx_next   = req.read_index;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next   = ST_DONE;
                rd_left_next  = '0;
                rd_right_next = '0;
                rd_valid_next = 1'b0;
                state_next    = S_OUT;
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (b_reg < a_reg)
                        begin
                            status_next = ST_INVALID;
                        end
                        else if (hit_any)
                        begin
                            op          = OP_MERGE_START;
                            status_next = ST_MERGED;
                            state_next  = S_MERGE;
                        end
                        else if (count_reg == CW'(TABLE_DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            op          = OP_INSERT;
                            count_next  = count_reg + CW'(1);
                            status_next = ST_NEW;
                        end
                    end
                    CMD_READ:
                    begin
                        if (in_range)
                        begin
                            rd_left_next  = rd_left_bus;
                            rd_right_next = rd_right_bus;
                            rd_valid_next = 1'b1;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_MERGE:
            begin
                // one absorbed neighbor per cycle until the widened entry is clear
                if (any_ovl)
                begin
                    op         = OP_MERGE_STEP;
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = count_x[COUNT_W-1:0];
                    out_left_next   = rd_left_reg;
                    out_right_next  = rd_right_reg;
                    out_ev_next     = rd_valid_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            idx_reg        <= '0;
            count_reg      <= '0;
            status_reg     <= '0;
            rd_left_reg    <= '0;
            rd_right_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= '0;
            out_count_reg  <= '0;
            out_left_reg   <= '0;
            out_right_reg  <= '0;
            out_ev_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            a_reg          <= a_next;
            b_reg          <= b_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            status_reg     <= status_next;
            rd_left_reg    <= rd_left_next;
            rd_right_reg   <= rd_right_next;
            rd_valid_reg   <= rd_valid_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
            out_left_reg   <= out_left_next;
            out_right_reg  <= out_right_next;
            out_ev_reg     <= out_ev_next;
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.entry_left  = out_left_reg;
    assign rsp.entry_right = out_right_reg;
    assign rsp.entry_valid = out_ev_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_first_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && cmd_reg == CMD_INSERT && b_reg >= a_reg && hit_any)
        |-> $onehot(first_vec))
        else $error("overlapping cells not contiguous");

    a_mark_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> $onehot(mark_vec))
        else $error("merge without exactly one marked cell");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE && any_ovl) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("compaction step did not drop one entry");

endmodule

// ===== rtl/simt_cell.sv =====
// One table slot: holds an interval, compares it and moves data to/from its neighbors.
module simt_cell #(
    parameter int POS_WIDTH = simt_pkg::POS_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  simt_pkg::cell_op_t    op,
    input  logic [POS_WIDTH-1:0]  a,
    input  logic [POS_WIDTH-1:0]  b,
    input  logic                  valid,
    input  logic                  next_valid,
    input  logic [POS_WIDTH-1:0]  prev_left,
    input  logic [POS_WIDTH-1:0]  prev_right,
    input  logic [POS_WIDTH-1:0]  next_left,
    input  logic [POS_WIDTH-1:0]  next_right,
    input  simt_pkg::cell_flags_t prev_flags,
    output simt_pkg::cell_flags_t flags,
    output logic [POS_WIDTH-1:0]  left,
    output logic [POS_WIDTH-1:0]  right
);
    import simt_pkg::*;

    logic [POS_WIDTH-1:0] left_reg;
    logic [POS_WIDTH-1:0] left_next;
    logic [POS_WIDTH-1:0] right_reg;
    logic [POS_WIDTH-1:0] right_next;
    logic                 mark_reg;
    logic                 mark_next;
    logic                 beyond_reg;
    logic                 beyond_next;
    logic                 ins_slot;

    always_comb
    begin
        flags.r     = valid && (right_reg >= a);
        flags.hit   = flags.r && (left_reg <= b);
        flags.first = flags.hit && !prev_flags.r;
        flags.ge    = !valid || (left_reg > b);
        flags.ovl   = mark_reg && next_valid && (next_left <= right_reg);
        flags.mark  = mark_reg;
        ins_slot    = flags.ge && !prev_flags.ge;
    end

    always_comb
    begin
        left_next   = left_reg;
        right_next  = right_reg;
        mark_next   = mark_reg;
        beyond_next = beyond_reg;
        case (op)
            OP_INSERT:
            begin
                if (ins_slot)
                begin
                    left_next  = a;
                    right_next = b;
                end
                else if (prev_flags.ge)
                begin
                    left_next  = prev_left;
                    right_next = prev_right;
                end
            end
            OP_MERGE_START:
            begin
                mark_next   = flags.first;
                beyond_next = prev_flags.r;
                if (flags.first)
                begin
                    left_next  = (left_reg < a) ? left_reg : a;
                    right_next = (right_reg > b) ? right_reg : b;
                end
            end
            OP_MERGE_STEP:
            begin
                // marked cell absorbs its upper neighbor, everything above moves down
                if (mark_reg)
                begin
                    right_next = (next_right > right_reg) ? next_right : right_reg;
                end
                else if (beyond_reg)
                begin
                    left_next  = next_left;
                    right_next = next_right;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mark_reg   <= 1'b0;
            beyond_reg <= 1'b0;
        end
        else
        begin
            mark_reg   <= mark_next;
            beyond_reg <= beyond_next;
        end
    end

    assign left  = left_reg;
    assign right = right_reg;

endmodule
